// ----- rtl/iau_pkg.sv -----
`default_nettype none
package iau_pkg;

    localparam int DW = 32;
    localparam int WW = 2 * DW;
    localparam int SW = $clog2(DW);
    localparam int CORNERS = 4;

    typedef logic signed [DW-1:0] t_word;
    typedef logic signed [WW-1:0] t_wide;
    typedef logic [DW-1:0]        t_mag;

    typedef enum logic [2:0] {
        FN_ADD,
        FN_SUB,
        FN_MUL,
        FN_DIV,
        FN_REM,
        FN_SHL,
        FN_LSHR,
        FN_ASHR
    } t_func;

    localparam t_word WORD_MAX = {1'b0, {(DW-1){1'b1}}};
    localparam t_word WORD_MIN = {1'b1, {(DW-1){1'b0}}};

    typedef struct packed {
        t_func func;
        t_word a_lo;
        t_word a_hi;
        logic  a_top;
        t_word b_lo;
        t_word b_hi;
        logic  b_top;
    } t_operands;

    typedef struct packed {
        t_func                      func;
        logic                       top;
        logic                       bad;
        logic                       bounds;
        t_wide [CORNERS-1:0]        c;
        logic  [CORNERS-1:0]        q_neg;
        logic  [CORNERS-1:0]        r_neg;
    } t_side;

    typedef struct packed {
        t_mag [CORNERS-1:0] dvd;
        t_mag [CORNERS-1:0] dvsr;
    } t_div_in;

    typedef struct packed {
        t_word r_lo;
        t_word r_hi;
        logic  r_top;
        logic  bad_operand;
        logic  saturated;
    } t_result;

endpackage
`default_nettype wire

// ----- rtl/iau_if.sv -----
`default_nettype none
interface iau_in_if;
    import iau_pkg::*;
    logic  valid;
    logic  ready;
    logic [2:0] func;
    t_word a_lo;
    t_word a_hi;
    logic  a_top;
    t_word b_lo;
    t_word b_hi;
    logic  b_top;

    modport source (output valid, func, a_lo, a_hi, a_top, b_lo, b_hi, b_top, input ready);
    modport sink (input valid, func, a_lo, a_hi, a_top, b_lo, b_hi, b_top, output ready);
endinterface

interface iau_out_if;
    import iau_pkg::*;
    logic  valid;
    logic  ready;
    t_word r_lo;
    t_word r_hi;
    logic  r_top;
    logic  bad_operand;
    logic  saturated;

    modport source (output valid, r_lo, r_hi, r_top, bad_operand, saturated, input ready);
    modport sink (input valid, r_lo, r_hi, r_top, bad_operand, saturated, output ready);
endinterface
`default_nettype wire

// ----- rtl/iau_corner.sv -----
`default_nettype none
module iau_corner (
    input  iau_pkg::t_operands i_op,
    output iau_pkg::t_side     o_side,
    output iau_pkg::t_div_in   o_div
);
    import iau_pkg::*;

    always_comb begin
        t_word       x;
        t_word       y;
        logic [SW-1:0] s;
        logic        in_top;
        logic        bad;
        t_wide       lo;
        t_wide       hi;
        o_side = '0;
        o_div  = '0;
        in_top = i_op.a_top | i_op.b_top;
        bad    = 1'b0;
        case (i_op.func)
            FN_DIV, FN_REM: begin
                bad = (i_op.b_lo == '0) || (i_op.b_hi == '0);
            end
            FN_SHL, FN_LSHR, FN_ASHR: begin
                bad = (t_mag'(i_op.b_lo) >= t_mag'(DW)) || (t_mag'(i_op.b_hi) >= t_mag'(DW));
            end
            default: begin
                bad = 1'b0;
            end
        endcase
        o_side.func   = i_op.func;
        o_side.bad    = bad & ~in_top;
        o_side.top    = in_top | bad;
        o_side.bounds = (i_op.func == FN_ADD) || (i_op.func == FN_SUB);
        for (int k = 0; k < CORNERS; k++) begin
            x = (k < 2) ? i_op.a_lo : i_op.a_hi;
            y = k[0] ? i_op.b_hi : i_op.b_lo;
            s = y[SW-1:0];
            o_side.q_neg[k] = x[DW-1] ^ y[DW-1];
            o_side.r_neg[k] = x[DW-1];
            o_div.dvd[k]  = x[DW-1] ? t_mag'(-x) : t_mag'(x);
            o_div.dvsr[k] = y[DW-1] ? t_mag'(-y) : t_mag'(y);
            case (i_op.func)
                FN_MUL:  o_side.c[k] = t_wide'(x) * t_wide'(y);
                FN_SHL:  o_side.c[k] = t_wide'(x) <<< s;
                FN_LSHR: o_side.c[k] = t_wide'(t_word'($unsigned(x) >> s));
                FN_ASHR: o_side.c[k] = t_wide'(x >>> s);
                default: o_side.c[k] = '0;
            endcase
        end
        if (i_op.func == FN_SUB) begin
            lo = t_wide'(i_op.a_lo) - t_wide'(i_op.b_hi);
            hi = t_wide'(i_op.a_hi) - t_wide'(i_op.b_lo);
        end else begin
            lo = t_wide'(i_op.a_lo) + t_wide'(i_op.b_lo);
            hi = t_wide'(i_op.a_hi) + t_wide'(i_op.b_hi);
        end
        if (o_side.bounds) begin
            o_side.c[0] = lo;
            o_side.c[1] = lo;
            o_side.c[2] = hi;
            o_side.c[3] = hi;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/iau_div.sv -----
`default_nettype none
module iau_div (
    input  wire            i_clk,
    input  wire            i_en,
    input  iau_pkg::t_mag  i_dvd,
    input  iau_pkg::t_mag  i_dvsr,
    output iau_pkg::t_mag  o_quo,
    output iau_pkg::t_mag  o_rem
);
    import iau_pkg::*;

    t_mag        r_p [0:DW];
    t_mag        r_q [0:DW];
    t_mag        r_d [0:DW-1];
    t_mag        n_p [1:DW];
    t_mag        n_q [1:DW];
    logic [DW:0] t_acc [1:DW];

    always_comb begin
        for (int k = 1; k <= DW; k++) begin
            t_acc[k] = {r_p[k-1], r_q[k-1][DW-1]};
            if (t_acc[k] >= {1'b0, r_d[k-1]}) begin
                n_p[k] = t_mag'(t_acc[k] - {1'b0, r_d[k-1]});
                n_q[k] = {r_q[k-1][DW-2:0], 1'b1};
            end else begin
                n_p[k] = t_acc[k][DW-1:0];
                n_q[k] = {r_q[k-1][DW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p[0] <= '0;
            r_q[0] <= i_dvd;
            r_d[0] <= i_dvsr;
            for (int k = 1; k <= DW; k++) begin
                r_p[k] <= n_p[k];
                r_q[k] <= n_q[k];
            end
            for (int k = 1; k < DW; k++) begin
                r_d[k] <= r_d[k-1];
            end
        end
    end

    assign o_quo = r_q[DW];
    assign o_rem = r_p[DW];

endmodule
`default_nettype wire

// ----- rtl/interval_arithmetic_unit.sv -----
// Interval arithmetic unit: takes two signed 32-bit intervals with unknown flags and an
// operation, and returns the saturated result interval with unknown, bad-operand and
// saturation flags. One beat enters every cycle unless the output stalls; each result
// passes the input register, the four pipelined corner dividers, one quotient bit per
// stage, and the min/max and output registers, a path every operation takes so that
// results stay in order. A stall at the output holds the whole pipeline.
`default_nettype none
module interval_arithmetic_unit (
    input  wire       i_clk,
    input  wire       i_rst_n,
    iau_in_if.sink    i_in,
    iau_out_if.source o_out
);
    import iau_pkg::*;

    typedef struct packed {
        logic  top;
        logic  bad;
        t_wide lo_a;
        t_wide lo_b;
        t_wide hi_a;
        t_wide hi_b;
    } t_minmax;

    logic      en;
    logic      r_s1_valid;
    t_operands r_s1;
    t_side     side_in;
    t_div_in   div_in;
    logic      r_vld [0:DW];
    t_side     r_side [0:DW];
    t_mag      quo [CORNERS];
    t_mag      rem [CORNERS];
    logic      r_mm_valid;
    t_minmax   r_mm;
    t_minmax   n_mm;
    logic      r_out_valid;
    t_result   r_out;
    t_result   n_out;

    assign en         = !r_out_valid || o_out.ready;
    assign i_in.ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (en) begin
            r_s1_valid <= i_in.valid;
        end
        if (en) begin
            r_s1.func  <= t_func'(i_in.func);
            r_s1.a_lo  <= i_in.a_lo;
            r_s1.a_hi  <= i_in.a_hi;
            r_s1.a_top <= i_in.a_top;
            r_s1.b_lo  <= i_in.b_lo;
            r_s1.b_hi  <= i_in.b_hi;
            r_s1.b_top <= i_in.b_top;
        end
    end

    iau_corner u_corner (
        .i_op   (r_s1),
        .o_side (side_in),
        .o_div  (div_in)
    );

    for (genvar g = 0; g < CORNERS; g++) begin : g_div
        iau_div u_div (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_dvd  (div_in.dvd[g]),
            .i_dvsr (div_in.dvsr[g]),
            .o_quo  (quo[g]),
            .o_rem  (rem[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= DW; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (en) begin
            r_vld[0] <= r_s1_valid;
            for (int k = 1; k <= DW; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
        if (en) begin
            r_side[0] <= side_in;
            for (int k = 1; k <= DW; k++) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    always_comb begin
        t_wide c [CORNERS];
        t_wide v;
        for (int k = 0; k < CORNERS; k++) begin
            c[k] = $signed(r_side[DW].c[k]);
            case (r_side[DW].func)
                FN_DIV: begin
                    v    = t_wide'(quo[k]);
                    c[k] = r_side[DW].q_neg[k] ? -v : v;
                end
                FN_REM: begin
                    v    = t_wide'(rem[k]);
                    c[k] = r_side[DW].r_neg[k] ? -v : v;
                end
                default: begin
                    v = '0;
                end
            endcase
        end
        n_mm.top = r_side[DW].top;
        n_mm.bad = r_side[DW].bad;
        if (r_side[DW].bounds) begin
            n_mm.lo_a = c[0];
            n_mm.lo_b = c[0];
            n_mm.hi_a = c[3];
            n_mm.hi_b = c[3];
        end else begin
            n_mm.lo_a = (c[1] < c[0]) ? c[1] : c[0];
            n_mm.hi_a = (c[1] > c[0]) ? c[1] : c[0];
            n_mm.lo_b = (c[3] < c[2]) ? c[3] : c[2];
            n_mm.hi_b = (c[3] > c[2]) ? c[3] : c[2];
        end
    end

    always_comb begin
        t_wide lo;
        t_wide hi;
        logic  sat;
        lo  = ($signed(r_mm.lo_b) < $signed(r_mm.lo_a)) ? r_mm.lo_b : r_mm.lo_a;
        hi  = ($signed(r_mm.hi_b) > $signed(r_mm.hi_a)) ? r_mm.hi_b : r_mm.hi_a;
        sat = 1'b0;
        n_out.r_lo = t_word'(lo);
        n_out.r_hi = t_word'(hi);
        if (lo > t_wide'(WORD_MAX)) begin
            n_out.r_lo = WORD_MAX;
            sat        = 1'b1;
        end else if (lo < t_wide'(WORD_MIN)) begin
            n_out.r_lo = WORD_MIN;
            sat        = 1'b1;
        end
        if (hi > t_wide'(WORD_MAX)) begin
            n_out.r_hi = WORD_MAX;
            sat        = 1'b1;
        end else if (hi < t_wide'(WORD_MIN)) begin
            n_out.r_hi = WORD_MIN;
            sat        = 1'b1;
        end
        n_out.r_top       = r_mm.top;
        n_out.bad_operand = r_mm.bad;
        n_out.saturated   = sat & ~r_mm.top;
        if (r_mm.top) begin
            n_out.r_lo = '0;
            n_out.r_hi = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mm_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_mm_valid  <= r_vld[DW];
            r_out_valid <= r_mm_valid;
        end
        if (en) begin
            r_mm  <= n_mm;
            r_out <= n_out;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.r_lo        = r_out.r_lo;
    assign o_out.r_hi        = r_out.r_hi;
    assign o_out.r_top       = r_out.r_top;
    assign o_out.bad_operand = r_out.bad_operand;
    assign o_out.saturated   = r_out.saturated;

    a_top_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.r_top) |-> (o_out.r_lo == '0 && o_out.r_hi == '0))
        else $error("Unknown result carries nonzero bounds.");

    a_bad_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.bad_operand) |-> o_out.r_top)
        else $error("Bad operand without unknown result.");

    a_sat_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.saturated) |-> !o_out.r_top)
        else $error("Saturation flagged on unknown result.");

endmodule
`default_nettype wire

// ----- tb/interval_arithmetic_unit_test.sv -----
`timescale 1ns / 1ps
`default_nettype none

class iau_scoreboard;
    iau_pkg::t_result pending[$];
    int errors;

    function new();
        errors = 0;
    endfunction

    static function longint clamp_word(longint x, ref bit sat);
        if (x > 64'sd2147483647) begin
            sat = 1;
            return 64'sd2147483647;
        end
        if (x < -64'sd2147483648) begin
            sat = 1;
            return -64'sd2147483648;
        end
        return x;
    endfunction

    static function longint corner_value(iau_pkg::t_func fn, longint x, longint y);
        longint q;
        case (fn)
            iau_pkg::FN_MUL: q = x * y;
            iau_pkg::FN_DIV: q = x / y;
            iau_pkg::FN_REM: q = (y == -1) ? 0 : x % y;
            iau_pkg::FN_SHL: q = x <<< y;
            iau_pkg::FN_LSHR: q = longint'($signed(32'(x) >> y));
            default: q = x >>> y;
        endcase
        return q;
    endfunction

    function void note_operands(iau_pkg::t_operands op);
        iau_pkg::t_result r;
        longint alo, ahi, blo, bhi, lo, hi;
        longint c[4];
        bit top, bad, sat;
        alo = op.a_lo;
        ahi = op.a_hi;
        blo = op.b_lo;
        bhi = op.b_hi;
        top = op.a_top | op.b_top;
        bad = 0;
        sat = 0;
        lo = 0;
        hi = 0;
        if (!top) begin
            if (op.func == iau_pkg::FN_DIV || op.func == iau_pkg::FN_REM)
                bad = (blo == 0 || bhi == 0);
            else if (op.func >= iau_pkg::FN_SHL)
                bad = (blo < 0 || blo > 31 || bhi < 0 || bhi > 31);
            if (bad) begin
                top = 1;
            end else if (op.func == iau_pkg::FN_ADD) begin
                lo = alo + blo;
                hi = ahi + bhi;
            end else if (op.func == iau_pkg::FN_SUB) begin
                lo = alo - bhi;
                hi = ahi - blo;
            end else begin
                c[0] = corner_value(op.func, alo, blo);
                c[1] = corner_value(op.func, alo, bhi);
                c[2] = corner_value(op.func, ahi, blo);
                c[3] = corner_value(op.func, ahi, bhi);
                lo = c[0];
                hi = c[0];
                for (int k = 1; k < 4; k++) begin
                    if (c[k] < lo) lo = c[k];
                    if (c[k] > hi) hi = c[k];
                end
            end
            if (!top) begin
                lo = clamp_word(lo, sat);
                hi = clamp_word(hi, sat);
            end
        end
        if (top) begin
            lo = 0;
            hi = 0;
            sat = 0;
        end
        r.r_lo = lo[31:0];
        r.r_hi = hi[31:0];
        r.r_top = top;
        r.bad_operand = bad;
        r.saturated = sat;
        pending.push_back(r);
    endfunction

    function void check_result(iau_pkg::t_result got);
        iau_pkg::t_result want;
        if (pending.size() == 0) begin
            $display("%0t: unexpected result %h", $time, got);
            errors++;
            return;
        end
        want = pending.pop_front();
        if (want.r_lo !== got.r_lo)
            $display("%0t: r_lo expected %0d actual %0d", $time, want.r_lo, got.r_lo);
        if (want.r_hi !== got.r_hi)
            $display("%0t: r_hi expected %0d actual %0d", $time, want.r_hi, got.r_hi);
        if (want.r_top !== got.r_top)
            $display("%0t: r_top expected %b actual %b", $time, want.r_top, got.r_top);
        if (want.bad_operand !== got.bad_operand)
            $display("%0t: bad_operand expected %b actual %b", $time, want.bad_operand,
                got.bad_operand);
        if (want.saturated !== got.saturated)
            $display("%0t: saturated expected %b actual %b", $time, want.saturated,
                got.saturated);
        if (want !== got) errors++;
    endfunction
endclass

module interval_arithmetic_unit_test;
    import iau_pkg::*;

    localparam int RANDOM_BEATS = 1280;
    localparam int STALL_LIMIT = 2000;

    logic i_clk = 0;
    logic i_rst_n = 0;
    bit hold_off = 0;
    int idle_cycles = 0;
    iau_scoreboard interval_board;

    iau_in_if in_bus();
    iau_out_if out_bus();

    interval_arithmetic_unit uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in(in_bus.sink),
        .o_out(out_bus.source)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        in_bus.valid = 0;
        in_bus.func = '0;
        in_bus.a_lo = '0;
        in_bus.a_hi = '0;
        in_bus.a_top = 0;
        in_bus.b_lo = '0;
        in_bus.b_hi = '0;
        in_bus.b_top = 0;
        out_bus.ready = 0;
    end

    function automatic t_word pick_bound();
        case ($urandom_range(0, 7))
            0: return WORD_MAX;
            1: return WORD_MIN;
            2: return t_word'($urandom_range(0, 4)) - 2;
            3: return t_word'($urandom_range(0, 200)) - 100;
            4: return t_word'($urandom_range(0, 65535)) - 32768;
            default: return t_word'($urandom);
        endcase
    endfunction

    task automatic send_beat(t_func fn, t_word alo, t_word ahi, logic at,
                             t_word blo, t_word bhi, logic bt, bit gaps);
        int gap;
        gap = gaps ? $urandom_range(0, 13) : 0;
        if ($urandom_range(0, 3) == 0) gap = 0;
        repeat (gap) begin
            in_bus.valid <= 0;
            @(posedge i_clk);
        end
        in_bus.valid <= 1;
        in_bus.func <= fn;
        in_bus.a_lo <= alo;
        in_bus.a_hi <= ahi;
        in_bus.a_top <= at;
        in_bus.b_lo <= blo;
        in_bus.b_hi <= bhi;
        in_bus.b_top <= bt;
        do @(posedge i_clk); while (!in_bus.ready);
    endtask

    always @(posedge i_clk) begin
        t_operands op;
        if (i_rst_n && in_bus.valid && in_bus.ready) begin
            op.func = t_func'(in_bus.func);
            op.a_lo = in_bus.a_lo;
            op.a_hi = in_bus.a_hi;
            op.a_top = in_bus.a_top;
            op.b_lo = in_bus.b_lo;
            op.b_hi = in_bus.b_hi;
            op.b_top = in_bus.b_top;
            interval_board.note_operands(op);
        end
    end

    always @(posedge i_clk) begin
        t_result got;
        if (i_rst_n && out_bus.valid && out_bus.ready) begin
            got.r_lo = out_bus.r_lo;
            got.r_hi = out_bus.r_hi;
            got.r_top = out_bus.r_top;
            got.bad_operand = out_bus.bad_operand;
            got.saturated = out_bus.saturated;
            interval_board.check_result(got);
        end
    end

    initial begin
        int wait_left;
        wait (i_rst_n);
        forever begin
            wait_left = $urandom_range(0, 13);
            if ($urandom_range(0, 2) == 0) wait_left = 0;
            while (wait_left > 0 || hold_off) begin
                out_bus.ready <= 0;
                @(posedge i_clk);
                if (!hold_off) wait_left--;
            end
            out_bus.ready <= 1;
            do @(posedge i_clk); while (!out_bus.valid && !hold_off);
        end
    end

    always @(posedge i_clk) begin
        if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("interval_arithmetic_unit: mismatch");
            $finish;
        end
    end

    initial begin
        hold_off = 0;
        wait (i_rst_n);
        repeat (300) @(posedge i_clk);
        hold_off = 1;
        repeat (150) @(posedge i_clk);
        hold_off = 0;
    end

    initial begin
        t_word lo, hi;
        interval_board = new();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        send_beat(FN_ADD, WORD_MAX, WORD_MAX, 0, 1, 1, 0, 0);
        send_beat(FN_ADD, WORD_MIN, WORD_MIN, 0, -1, -1, 0, 0);
        send_beat(FN_SUB, WORD_MIN, WORD_MAX, 0, WORD_MIN, 5, 0, 0);
        send_beat(FN_MUL, WORD_MIN, WORD_MAX, 0, WORD_MIN, -1, 0, 0);
        send_beat(FN_MUL, 7, 3, 0, -4, 9, 0, 0);
        send_beat(FN_DIV, WORD_MIN, 100, 0, -1, 3, 0, 0);
        send_beat(FN_DIV, 5, 9, 0, 0, 4, 0, 0);
        send_beat(FN_REM, WORD_MIN, -7, 0, -1, 3, 0, 0);
        send_beat(FN_REM, 5, 9, 0, -3, 0, 0, 0);
        send_beat(FN_SHL, -3, 5, 0, 0, 31, 0, 0);
        send_beat(FN_SHL, 1, 1, 0, 32, 3, 0, 0);
        send_beat(FN_LSHR, -1, WORD_MIN, 0, 0, 31, 0, 0);
        send_beat(FN_LSHR, 4, 8, 0, -1, 2, 0, 0);
        send_beat(FN_ASHR, WORD_MIN, -1, 0, 31, 1, 0, 0);
        send_beat(FN_ASHR, -9, 9, 0, 3, 3, 0, 0);
        send_beat(FN_ADD, 1, 2, 1, 3, 4, 0, 0);
        send_beat(FN_DIV, 1, 2, 0, 0, 0, 1, 0);
        send_beat(FN_SUB, 10, -10, 0, 5, -5, 0, 0);
        send_beat(FN_MUL, '1, '1, 1, '1, '1, 1, 0);

        for (int n = 0; n < RANDOM_BEATS; n++) begin
            t_func fn;
            t_word blo, bhi;
            fn = t_func'($urandom_range(0, 7));
            lo = pick_bound();
            hi = pick_bound();
            if ($urandom_range(0, 3) != 0 && lo > hi) {lo, hi} = {hi, lo};
            blo = pick_bound();
            bhi = pick_bound();
            if (fn >= FN_SHL && $urandom_range(0, 7) != 0) begin
                blo = $urandom_range(0, 31);
                bhi = $urandom_range(0, 31);
            end
            if ($urandom_range(0, 3) != 0 && blo > bhi) {blo, bhi} = {bhi, blo};
            send_beat(fn, lo, hi, $urandom_range(0, 15) == 0, blo, bhi,
                $urandom_range(0, 15) == 0, 1);
        end
        in_bus.valid <= 0;

        while (interval_board.pending.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (interval_board.errors == 0) begin
            $display("interval_arithmetic_unit: match");
        end else begin
            $display("interval_arithmetic_unit: mismatch");
        end
        $finish;
    end
endmodule

`default_nettype wire
